### rtl/fcomp_pkg.sv
// ============================================================================
// fcomp_pkg: focuser temperature compensation shared definitions
// Field widths, temperature limits and configuration register indexes.
// ============================================================================
`default_nettype none

package fcomp_pkg;

   // Field widths
   localparam int TempWidth   = 12;
   localparam int PosWidth    = 24;
   localparam int StepWidth   = 16;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDatWidth = 24;

   // Temperature limits in 1/16 degree C (a sample must lie strictly inside)
   localparam logic signed [TempWidth-1:0] TempLowLimit  = -12'sd640;
   localparam logic signed [TempWidth-1:0] TempHighLimit = 12'sd1280;
   localparam logic signed [TempWidth-1:0] TempDefault   = 12'sd320;

   // Drift of one degree C, on the widened difference
   localparam logic signed [TempWidth:0] DriftThreshold    = 13'sd16;
   localparam logic signed [TempWidth:0] DriftThresholdNeg = -13'sd16;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CsrProbeRunning    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrMoveInwardOnFall = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrStepsPerDegree  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrMaxPosition     = 2'd3;

endpackage

`default_nettype wire

### rtl/focuser_temperature_compensation_unit.sv
// ============================================================================
// focuser_temperature_compensation_unit: probe filter and focus drift control
// Filters probe samples, tracks a reference temperature and moves the focuser
// target by a configured step count for each degree of drift.
// ============================================================================
//
//   Channel | Prefix | Direction | Contents
//   --------+--------+-----------+--------------------------------------------
//   request | req_   | in        | sample_temp, comp_enable, target_in
//   result  | rsp_   | out       | temp_out, target_out, target_moved,
//           |        |           | start_conversion
//   config  | csr_   | in        | write enable, index, data (no read-back)
//
// One transaction per cycle unless stalled: the whole tick is evaluated
// combinationally from the request ports and the held state, and lands in
// the result register; the result is valid in the cycle after the accept.
// A request is taken whenever the result register is empty or being drained
// in the same cycle, so only a stalled, full result register stalls requests.
// Synchronous reset sets all state but result data; no clearing pass.
`default_nettype none

module focuser_temperature_compensation_unit (
   input  wire                                    clock,
   input  wire                                    reset,
   // Request channel
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire  logic signed [fcomp_pkg::TempWidth-1:0] req_sample_temp,
   input  wire                                    req_comp_enable,
   input  wire  [fcomp_pkg::PosWidth-1:0]         req_target_in,
   // Result channel
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic signed [fcomp_pkg::TempWidth-1:0] rsp_temp_out,
   output logic [fcomp_pkg::PosWidth-1:0]         rsp_target_out,
   output logic                                   rsp_target_moved,
   output logic                                   rsp_start_conversion,
   // Configuration port
   input  wire                                    csr_write_enable,
   input  wire  [fcomp_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire  [fcomp_pkg::CsrDatWidth-1:0]      csr_write_data
);

   import fcomp_pkg::*;

   // Configuration registers
   logic                 probe_running_ff;
   logic                 move_inward_ff;
   logic [StepWidth-1:0] steps_per_degree_ff;
   logic [PosWidth-1:0]  max_position_ff;

   // Tick state
   logic signed [TempWidth-1:0] last_valid_ff, last_valid_in;
   logic signed [TempWidth-1:0] current_temp_ff, current_temp_in;
   logic signed [TempWidth-1:0] reference_ff, reference_in;
   logic                        read_phase_ff, read_phase_in;
   logic                        prev_enable_ff, prev_enable_in;
   logic                        enable_seen_ff, enable_seen_in;

   // Result register
   logic                        rsp_valid_ff;
   logic signed [TempWidth-1:0] temp_out_ff, temp_out_in;
   logic [PosWidth-1:0]         target_out_ff, target_out_in;
   logic                        moved_ff, moved_in;
   logic                        start_ff, start_in;

   // Working signals
   logic                        req_fire;
   logic                        sample_ok;
   logic signed [TempWidth-1:0] read_value;
   logic                        capture;
   logic signed [TempWidth-1:0] reference_mid;
   logic signed [TempWidth-1:0] current_mid;
   logic signed [TempWidth:0]   temp_diff;
   logic                        drift;
   logic                        falling;
   logic                        decrease;
   logic [PosWidth:0]           sum_pos;
   logic [PosWidth-1:0]         dec_pos;
   logic [PosWidth:0]           new_pos;

   // The result register drains or is empty: a new transaction can enter.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_running_ff    <= 1'b0;
         move_inward_ff      <= 1'b0;
         steps_per_degree_ff <= '0;
         max_position_ff     <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrProbeRunning:     probe_running_ff    <= csr_write_data[0];
            CsrMoveInwardOnFall: move_inward_ff      <= csr_write_data[0];
            CsrStepsPerDegree:   steps_per_degree_ff <= csr_write_data[StepWidth-1:0];
            CsrMaxPosition:      max_position_ff     <= csr_write_data[PosWidth-1:0];
         endcase
      end
   end

   // Probe read: a sample strictly inside the limits is used instead of the held value.
   assign sample_ok  = (req_sample_temp > TempLowLimit) && (req_sample_temp < TempHighLimit);
   assign read_value = sample_ok ? req_sample_temp : last_valid_ff;

   // A rising enable after the first running tick captures the reference.
   assign capture       = enable_seen_ff && (prev_enable_ff != req_comp_enable) &&
                          req_comp_enable;
   assign reference_mid = capture ? read_value : reference_ff;
   assign current_mid   = read_phase_ff ? read_value : current_temp_ff;

   // Drift test on the reference and current temperatures.
   assign temp_diff = {reference_mid[TempWidth-1], reference_mid} -
                      {current_mid[TempWidth-1], current_mid};
   assign drift     = (temp_diff >= DriftThreshold) || (temp_diff <= DriftThresholdNeg);
   assign falling   = current_mid < reference_mid;
   assign decrease  = move_inward_ff ? falling : !falling;

   // Target move: decrease saturates at zero, then clamp to the maximum.
   assign sum_pos = {1'b0, req_target_in} + {{(PosWidth + 1 - StepWidth){1'b0}},
                                            steps_per_degree_ff};
   assign dec_pos = (req_target_in >= {{(PosWidth - StepWidth){1'b0}}, steps_per_degree_ff})
                    ? req_target_in - {{(PosWidth - StepWidth){1'b0}}, steps_per_degree_ff}
                    : '0;
   assign new_pos = decrease ? {1'b0, dec_pos} : sum_pos;

   // Next state and result of one tick
   always_comb begin
      last_valid_in   = last_valid_ff;
      current_temp_in = current_temp_ff;
      reference_in    = reference_ff;
      read_phase_in   = read_phase_ff;
      prev_enable_in  = prev_enable_ff;
      enable_seen_in  = enable_seen_ff;
      temp_out_in     = last_valid_ff;
      target_out_in   = req_target_in;
      moved_in        = 1'b0;
      start_in        = 1'b0;
      if (probe_running_ff) begin
         enable_seen_in  = 1'b1;
         prev_enable_in  = req_comp_enable;
         read_phase_in   = !read_phase_ff;
         start_in        = !read_phase_ff;
         current_temp_in = current_mid;
         reference_in    = reference_mid;
         temp_out_in     = current_mid;
         if ((capture || read_phase_ff) && sample_ok) begin
            last_valid_in = req_sample_temp;
         end
         if (req_comp_enable && drift) begin
            moved_in     = 1'b1;
            reference_in = current_mid;
            if (new_pos > {1'b0, max_position_ff}) begin
               target_out_in = max_position_ff;
            end else begin
               target_out_in = new_pos[PosWidth-1:0];
            end
         end
      end
   end

   // Tick state update on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff   <= TempDefault;
         current_temp_ff <= '0;
         reference_ff    <= '0;
         read_phase_ff   <= 1'b0;
         prev_enable_ff  <= 1'b0;
         enable_seen_ff  <= 1'b0;
      end else if (req_fire) begin
         last_valid_ff   <= last_valid_in;
         current_temp_ff <= current_temp_in;
         reference_ff    <= reference_in;
         read_phase_ff   <= read_phase_in;
         prev_enable_ff  <= prev_enable_in;
         enable_seen_ff  <= enable_seen_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         temp_out_ff   <= temp_out_in;
         target_out_ff <= target_out_in;
         moved_ff      <= moved_in;
         start_ff      <= start_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_temp_out         = temp_out_ff;
   assign rsp_target_out       = target_out_ff;
   assign rsp_target_moved     = moved_ff;
   assign rsp_start_conversion = start_ff;

   // Assertions
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      req_fire && !probe_running_ff |=> !rsp_target_moved && !rsp_start_conversion)
      else $error("stopped probe produced a move or a conversion request");

   a_phase_toggles: assert property (@(posedge clock) disable iff (reset)
      req_fire && probe_running_ff |=> read_phase_ff != $past(read_phase_ff))
      else $error("read phase did not alternate on a running tick");

   a_target_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && moved_ff |-> target_out_ff <= max_position_ff)
      else $error("compensated target above max position");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("request stalled while the result register could take it");

   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      (last_valid_ff > TempLowLimit) && (last_valid_ff < TempHighLimit))
      else $error("held temperature outside the probe limits");

endmodule

`default_nettype wire
